@@ rtl/ple_pkg.sv @@
// Package for the positional list engine.
// Sizes, request and status codes, and the cell command struct; no dependencies.
package ple_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int POS_W      = 5;
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_ERASE  = 2'd1,
        FN_FIND   = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        logic             ins;
        logic             ers;
        logic             fnd;
        logic [IDX_W-1:0] pos;
        logic [CNT_W-1:0] len;
    } cell_cmd_t;

endpackage

@@ rtl/ple_cell.sv @@
// One list cell: holds one entry, shifts with its neighbors, compares for find.
// Depends on ple_pkg.
module ple_cell
    import ple_pkg::*;
(
    input  logic                  clk,
    input  logic [IDX_W-1:0]      idx,
    input  cell_cmd_t             cmd,
    input  logic [DATA_WIDTH-1:0] value,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    input  logic                  prior_in,
    output logic [DATA_WIDTH-1:0] data,
    output logic                  prior_out,
    output logic                  hit
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic [CNT_W-1:0]      idx_ext;
    logic                  match;

    assign idx_ext = CNT_W'(idx);

    always_comb
    begin
        data_next = data_reg;
        if (cmd.ins)
        begin
            if (idx == cmd.pos)
            begin
                data_next = value;
            end
            else if (idx > cmd.pos && idx_ext <= cmd.len)
            begin
                data_next = left_data;
            end
        end
        else if (cmd.ers && idx >= cmd.pos)
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign match     = cmd.fnd && (idx_ext < cmd.len) && (data_reg == value);
    assign hit       = match && !prior_in;
    assign prior_out = prior_in || match;
    assign data      = data_reg;

endmodule

@@ rtl/positional_list_engine.sv @@
// Top level of the positional list engine: row of list cells plus control.
// Depends on ple_pkg and ple_cell.
//
// Takes one item per clock cycle and returns its result in the next cycle from an
// output register; a new item is accepted while a result waits if that result is
// taken in the same cycle. Insert and erase shift all cells in parallel as the item
// is accepted, and find compares every cell at once, with a first-match chain
// running through the row to pick the lowest matching position. Entries above
// the length are never read, so the entry storage needs no clearing after reset.
module positional_list_engine
    import ple_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  logic [POS_W-1:0]   position,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic               found,
    output logic [3:0]         found_index,
    output logic [4:0]         count
);

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [CNT_W-1:0]      len_reg;
    logic [CNT_W-1:0]      len_next;
    status_t               status_reg;
    status_t               st;
    logic                  found_reg;
    logic [IDX_W-1:0]      found_index_reg;
    logic [IDX_W-1:0]      hit_index;
    logic [CNT_W-1:0]      count_reg;
    logic                  accept;
    cell_cmd_t             cmd;
    logic [DATA_WIDTH-1:0] word;
    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      len_ext;

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DEPTH:0]        prior;
    logic [DEPTH-1:0]      hit;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign word     = DATA_WIDTH'(value);
    assign pos_ext  = CMP_W'(position);
    assign len_ext  = CMP_W'(len_reg);

    always_comb
    begin
        st       = ST_DONE;
        len_next = len_reg;
        cmd.ins  = 1'b0;
        cmd.ers  = 1'b0;
        cmd.fnd  = 1'b0;
        cmd.pos  = IDX_W'(position);
        cmd.len  = len_reg;
        case (func_t'(func))
            FN_INSERT:
            begin
                if (len_reg == CNT_W'(DEPTH))
                begin
                    st = ST_FULL;
                end
                else if (pos_ext > len_ext)
                begin
                    st = ST_RANGE;
                end
                else
                begin
                    cmd.ins  = accept;
                    len_next = len_reg + CNT_W'(1);
                end
            end
            FN_ERASE:
            begin
                if (pos_ext >= len_ext)
                begin
                    st = ST_RANGE;
                end
                else
                begin
                    cmd.ers  = accept;
                    len_next = len_reg - CNT_W'(1);
                end
            end
            FN_FIND:
            begin
                cmd.fnd = 1'b1;
            end
            default:
            begin
                st = ST_DONE;
            end
        endcase
    end

    assign prior[0] = 1'b0;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            ple_cell u_cell (
                .clk        (clk),
                .idx        (IDX_W'(i)),
                .cmd        (cmd),
                .value      (word),
                .left_data  ((i == 0) ? word : cell_data[(i == 0) ? 0 : i - 1]),
                .right_data ((i == DEPTH - 1) ? cell_data[i]
                                              : cell_data[(i == DEPTH - 1) ? i : i + 1]),
                .prior_in   (prior[i]),
                .data       (cell_data[i]),
                .prior_out  (prior[i+1]),
                .hit        (hit[i])
            );
        end
    endgenerate

    always_comb
    begin
        hit_index = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            hit_index = hit_index | (hit[k] ? IDX_W'(k) : '0);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            len_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                len_reg <= len_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg      <= st;
            found_reg       <= prior[DEPTH];
            found_index_reg <= hit_index;
            count_reg       <= len_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign found_index = 4'(found_index_reg);
    assign count       = 5'(count_reg);

endmodule
